FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file mids_checker.sv of this project.
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/mids_pkg.sv
// Shared types, constants and kernel taps of the masked image downsampler.
// No dependencies; used by the lane, merge, divider and top-level modules.
package mids_pkg;

    // One stored pixel: red in the low bits, mask flag on top.
    typedef struct packed {
        logic       mask;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } pix_t;

    typedef logic [3:0] wt_t;

    // Weighted sums of one window row.
    typedef struct packed {
        logic [12:0] r;
        logic [12:0] g;
        logic [12:0] b;
        logic [5:0]  k;
    } lane_sum_t;

    // Weighted sums of the whole window.
    typedef struct packed {
        logic [17:0] r;
        logic [17:0] g;
        logic [17:0] b;
        logic [10:0] k;
    } tot_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    localparam int TAPS_N = 6;
    localparam int PIX_W  = 25;

    // Configuration register indexes.
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_KERNEL_SELECT = 2'd2;

    localparam wt_t TAPS [2][TAPS_N] = '{
        '{4'd1, 4'd5, 4'd10, 4'd10, 4'd5, 4'd1},
        '{4'd1, 4'd2, 4'd4,  4'd4,  4'd2, 4'd1}
    };

    // Kernel tap by position; positions past the kernel weigh nothing.
    function automatic wt_t tap(input logic sel, input logic [2:0] idx);
        wt_t w;
        w = '0;
        if (idx < 3'd6)
        begin
            w = TAPS[sel][idx];
        end
        return w;
    endfunction

endpackage

FILE: hw/rtl/mids_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; the read returns the old data on a same-address write.
module mids_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: hw/rtl/mids_lane.sv
// One row lane: weights the six pixels of a window row by the column taps.
// Depends on mids_pkg.
module mids_lane (
    input  logic              clk,
    input  logic              en,
    input  mids_pkg::pix_t    pix [6],
    input  mids_pkg::wt_t     wt [6],
    output mids_pkg::lane_sum_t sum
);
    import mids_pkg::*;

    lane_sum_t sum_next;

    // Masked pixels drop out of both the color sums and the weight sum.
    always_comb
    begin
        sum_next = '0;
        for (int j = 0; j < 6; j++)
        begin
            if (!pix[j].mask)
            begin
                sum_next.r = sum_next.r + 13'(wt[j] * pix[j].r);
                sum_next.g = sum_next.g + 13'(wt[j] * pix[j].g);
                sum_next.b = sum_next.b + 13'(wt[j] * pix[j].b);
                sum_next.k = sum_next.k + 6'(wt[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum <= sum_next;
        end
    end
endmodule

FILE: hw/rtl/mids_merge.sv
// Merging stage: combines the six lane sums with the row taps.
// Depends on mids_pkg.
module mids_merge (
    input  logic                clk,
    input  logic                en,
    input  mids_pkg::lane_sum_t lanes [6],
    input  mids_pkg::wt_t       wt [6],
    output mids_pkg::tot_t      tot
);
    import mids_pkg::*;

    tot_t tot_next;

    // Row-weighted sum over the lanes.
    always_comb
    begin
        tot_next = '0;
        for (int i = 0; i < 6; i++)
        begin
            tot_next.r = tot_next.r + 18'(wt[i] * lanes[i].r);
            tot_next.g = tot_next.g + 18'(wt[i] * lanes[i].g);
            tot_next.b = tot_next.b + 18'(wt[i] * lanes[i].b);
            tot_next.k = tot_next.k + 11'(wt[i] * lanes[i].k);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tot <= tot_next;
        end
    end
endmodule

FILE: hw/rtl/mids_div.sv
// Restoring divider: three color sums by the shared weight sum, one bit a cycle.
// Depends on mids_pkg. The quotient is known to fit in eight bits.
module mids_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  mids_pkg::tot_t num,
    output logic           done,
    output mids_pkg::rgb_t quot
);
    import mids_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [2:0]  cnt_reg;
    logic [17:0] dsh_reg;
    logic [17:0] rem_r_reg, rem_g_reg, rem_b_reg;
    rgb_t        q_reg;

    // One restoring step on a remainder.
    function automatic logic [18:0] step(input logic [17:0] rem, input logic [17:0] d);
        logic ge;
        ge = (rem >= d);
        return {ge, ge ? rem - d : rem};
    endfunction

    logic [18:0] st_r, st_g, st_b;

    assign st_r = step(rem_r_reg, dsh_reg);
    assign st_g = step(rem_g_reg, dsh_reg);
    assign st_b = step(rem_b_reg, dsh_reg);

    // Step counter and completion flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd7;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 3'd1;
                if (cnt_reg == 3'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainders, shifted divisor and quotient bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_r_reg <= num.r;
            rem_g_reg <= num.g;
            rem_b_reg <= num.b;
            dsh_reg   <= {num.k, 7'd0};
            q_reg     <= '0;
        end
        else if (busy_reg)
        begin
            rem_r_reg <= st_r[17:0];
            rem_g_reg <= st_g[17:0];
            rem_b_reg <= st_b[17:0];
            dsh_reg   <= dsh_reg >> 1;
            q_reg.r   <= {q_reg.r[6:0], st_r[18]};
            q_reg.g   <= {q_reg.g[6:0], st_g[18]};
            q_reg.b   <= {q_reg.b[6:0], st_b[18]};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

FILE: hw/rtl/masked_image_downsample.sv
// Sequence: an accepted item goes through LOAD, then per result slot SCAN, and for
// each result present SUM, MERGE, DIVGO, DIVW and PUT; empty slots are skipped in SCAN.
// An item causes up to 4 results; input stays closed until the last of them is put
// out, also while the output stalls; the 8-step divider is shared by all results.
// Reset: asynchronous, active low; clears positions, state and registers to
// 640 x 480, kernel 0. The five line RAMs are not cleared.
module masked_image_downsample #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
    input  logic        s_axis_tuser,   // masked_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // red_out, green_out, blue_out, out_row, out_col, zeros
    output logic        m_axis_tuser,   // masked_out
    output logic        m_axis_tlast,   // run_last
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import mids_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_MERGE = 3'd4;
    localparam logic [2:0] ST_DIVGO = 3'd5;
    localparam logic [2:0] ST_DIVW  = 3'd6;
    localparam logic [2:0] ST_PUT   = 3'd7;

    logic [2:0]    state_reg;
    logic [10:0]   width_reg, height_reg;
    logic          kernel_reg;
    logic [CW-1:0] col_reg, cur_col_reg;
    logic [RW-1:0] row_reg, cur_row_reg;
    logic [2:0]    slot_reg, cur_slot_reg;
    pix_t          cur_pix_reg;
    pix_t          win_reg [6][6];
    logic [1:0]    row_pres_reg, col_pres_reg;
    logic [1:0]    row_sb_reg, col_sb_reg;
    logic [8:0]    row_idx_reg [2];
    logic [8:0]    col_idx_reg [2];
    logic [1:0]    k_reg;

    logic          out_valid_reg;
    rgb_t          out_rgb_reg;
    logic          out_mask_reg, out_last_reg;
    logic [8:0]    out_row_reg, out_col_reg;

    logic [CW:0]   w;
    logic [RW:0]   h;
    logic          accept;
    pix_t          in_pix;
    logic [PIX_W-1:0] rd [5];
    logic [1:0]    w_sb, h_sb;
    logic [3:0]    pres;
    logic          last;
    logic [1:0]    rs, cs;
    wt_t           wr [6];
    wt_t           wc [6];
    lane_sum_t     lane_sum [6];
    tot_t          tot;
    rgb_t          quot;
    logic          div_done;
    logic          out_load;

    // Ring slot of a row a few rows below the given one.
    function automatic logic [2:0] slot_add(input logic [2:0] s, input logic [2:0] i);
        logic [3:0] t;
        t = {1'b0, s} + {1'b0, i};
        return (t >= 4'd5) ? 3'(t - 4'd5) : t[2:0];
    endfunction

    // Frame size limited to the supported range.
    always_comb
    begin
        if (width_reg < 11'd2)
            w = (CW+1)'(2);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w = (CW+1)'(MAX_WIDTH);
        else
            w = (CW+1)'(width_reg);
        if (height_reg < 11'd2)
            h = (RW+1)'(2);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h = (RW+1)'(MAX_HEIGHT);
        else
            h = (RW+1)'(height_reg);
    end

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_pix        = '{mask: s_axis_tuser, b: s_axis_tdata[23:16],
                             g: s_axis_tdata[15:8], r: s_axis_tdata[7:0]};

    // Five line RAMs, one per row slot; the current pixel goes in as it arrives.
    for (genvar s = 0; s < 5; s++)
    begin : g_line
        mids_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
            .clk   (clk),
            .we    (accept && (slot_reg == 3'(s))),
            .waddr (col_reg),
            .wdata (in_pix),
            .re    (accept),
            .raddr (col_reg),
            .rdata (rd[s])
        );
    end

    // Clamped windows near the right and bottom edge start one or two later.
    assign w_sb = w[0] ? 2'd1 : 2'd2;
    assign h_sb = h[0] ? 2'd1 : 2'd2;

    // Which of the up to four results this item causes.
    always_comb
    begin
        for (int m = 0; m < 4; m++)
        begin
            pres[m] = row_pres_reg[m / 2] && col_pres_reg[m % 2];
        end
        last = 1'b1;
        for (int m = 0; m < 4; m++)
        begin
            if (m > int'(k_reg) && pres[m])
                last = 1'b0;
        end
    end

    // Row and column taps of the current result.
    always_comb
    begin
        rs = k_reg[1] ? row_sb_reg : 2'd0;
        cs = k_reg[0] ? col_sb_reg : 2'd0;
        for (int i = 0; i < 6; i++)
        begin
            wr[i] = '0;
            wc[i] = '0;
            if (3'(i) >= {1'b0, rs} && {1'b0, cur_row_reg} >= (RW+1)'(5 - i))
                wr[i] = tap(kernel_reg, 3'(i) - {1'b0, rs});
            if (3'(i) >= {1'b0, cs} && {1'b0, cur_col_reg} >= (CW+1)'(5 - i))
                wc[i] = tap(kernel_reg, 3'(i) - {1'b0, cs});
        end
    end

    // Six row lanes and the merging stage.
    for (genvar i = 0; i < 6; i++)
    begin : g_lane
        mids_lane u_lane (
            .clk (clk),
            .en  (state_reg == ST_SUM),
            .pix (win_reg[i]),
            .wt  (wc),
            .sum (lane_sum[i])
        );
    end

    mids_merge u_merge (
        .clk   (clk),
        .en    (state_reg == ST_MERGE),
        .lanes (lane_sum),
        .wt    (wr),
        .tot   (tot)
    );

    mids_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_DIVGO),
        .num   (tot),
        .done  (div_done),
        .quot  (quot)
    );

    assign out_load = (state_reg == ST_PUT) && (!out_valid_reg || m_axis_tready);

    // Sequencer, positions and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= 11'd640;
            height_reg    <= 11'd480;
            kernel_reg    <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            slot_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (cfg_wr_en &&
                (cfg_index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_KERNEL_SELECT}))
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                    REG_KERNEL_SELECT: kernel_reg <= cfg_data[0];
                    default:           kernel_reg <= kernel_reg;
                endcase
                col_reg  <= '0;
                row_reg  <= '0;
                slot_reg <= '0;
            end
            else if (accept)
            begin
                if ({1'b0, col_reg} == w - 1'b1)
                begin
                    col_reg <= '0;
                    if ({1'b0, row_reg} == h - 1'b1)
                    begin
                        row_reg  <= '0;
                        slot_reg <= '0;
                    end
                    else
                    begin
                        row_reg  <= row_reg + 1'b1;
                        slot_reg <= (slot_reg == 3'd4) ? 3'd0 : slot_reg + 3'd1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                        state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    k_reg     <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (pres[k_reg])
                        state_reg <= ST_SUM;
                    else if (k_reg == 2'd3)
                        state_reg <= ST_IDLE;
                    else
                        k_reg <= k_reg + 2'd1;
                end
                ST_SUM:   state_reg <= ST_MERGE;
                ST_MERGE: state_reg <= ST_DIVGO;
                ST_DIVGO: state_reg <= ST_DIVW;
                ST_DIVW:
                begin
                    if (div_done)
                        state_reg <= ST_PUT;
                end
                ST_PUT:
                begin
                    if (out_load)
                    begin
                        if (k_reg == 2'd3)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Item capture, window shift and result positions.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_pix_reg  <= in_pix;
            cur_col_reg  <= col_reg;
            cur_row_reg  <= row_reg;
            cur_slot_reg <= slot_reg;
        end
        if (state_reg == ST_LOAD)
        begin
            for (int i = 0; i < 6; i++)
            begin
                for (int j = 0; j < 5; j++)
                begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
            end
            for (int i = 0; i < 5; i++)
            begin
                win_reg[i][5] <= pix_t'(rd[slot_add(cur_slot_reg, 3'(i))]);
            end
            win_reg[5][5] <= cur_pix_reg;

            row_pres_reg[0] <= cur_row_reg[0] && ({1'b0, cur_row_reg} >= (RW+1)'(3));
            row_pres_reg[1] <= ({1'b0, cur_row_reg} == h - 1'b1);
            col_pres_reg[0] <= cur_col_reg[0] && ({1'b0, cur_col_reg} >= (CW+1)'(3));
            col_pres_reg[1] <= ({1'b0, cur_col_reg} == w - 1'b1);
            row_sb_reg      <= h_sb;
            col_sb_reg      <= w_sb;
            row_idx_reg[0]  <= 9'(({1'b0, cur_row_reg} - (RW+1)'(3)) >> 1);
            row_idx_reg[1]  <= 9'(({1'b0, cur_row_reg} + (RW+1)'(h_sb) - (RW+1)'(3)) >> 1);
            col_idx_reg[0]  <= 9'(({1'b0, cur_col_reg} - (CW+1)'(3)) >> 1);
            col_idx_reg[1]  <= 9'(({1'b0, cur_col_reg} + (CW+1)'(w_sb) - (CW+1)'(3)) >> 1);
        end
        if (out_load)
        begin
            out_mask_reg <= (tot.k == 11'd0);
            out_rgb_reg  <= (tot.k == 11'd0) ? '0 : quot;
            out_row_reg  <= row_idx_reg[k_reg[1]];
            out_col_reg  <= col_idx_reg[k_reg[0]];
            out_last_reg <= last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_col_reg, out_row_reg,
                            out_rgb_reg.b, out_rgb_reg.g, out_rgb_reg.r};
    assign m_axis_tuser  = out_mask_reg;
    assign m_axis_tlast  = out_last_reg;
endmodule

FILE: hw/rtl/mids_checker.sv
// Port-level checks of the masked image downsampler, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mids_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    // A stalled result holds its place and value.
    `ASSERT_PROP(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // An empty window always gives black.
    `ASSERT_NEVER(a_masked_black, m_axis_tvalid && m_axis_tuser && m_axis_tdata[23:0] != 24'd0, "masked result has color")

    // One item is worked on at a time, so input closes right after an item.
    `ASSERT_PROP(a_one_item, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input open right after an item")
endmodule

bind masked_image_downsample mids_checker u_mids_checker (.*);

FILE: sim/tb_masked_image_downsample.sv
// Self-checking testbench of masked_image_downsample: streams RGB pixels with
// mask bits and checks each half-size result against a built-in predictor.
// Depends on mids_pkg and the masked_image_downsample RTL only.
`timescale 1ns / 1ps

module tb_masked_image_downsample;

    localparam int LIMIT_CYCLES  = 900000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int STORE_WIDTH   = 1024;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // One expected downsampled pixel.
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       masked;
        logic [8:0] row;
        logic [8:0] col;
        logic       last;
    } down_pixel_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // red_in, green_in, blue_in
    logic        s_axis_tuser;   // masked_in
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // red_out, green_out, blue_out, out_row, out_col, zeros
    logic        m_axis_tuser;   // masked_out
    logic        m_axis_tlast;   // run_last
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;

    // Predictor state: its own copy of registers, line rows and row tail.
    logic [10:0] img_width;
    logic [10:0] img_height;
    logic        kern_sel;
    logic [24:0] line_rows [5 * STORE_WIDTH];
    logic [24:0] row_tail [8];
    int          next_row;
    int          next_col;

    down_pixel_t expected_pixels [$];
    int          fail_count;
    int          cycle_count;
    int          src_idle_pct;
    int          snk_stall_pct;
    int          pixels_sent;

    masked_image_downsample i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Cycle counter with a hard limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stalls at the falling edge.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    function automatic int kern_tap(input logic sel, input int idx);
        int t;
        if (sel)
        begin
            case (idx)
                0, 5: t = 1;
                1, 4: t = 2;
                default: t = 4;
            endcase
        end
        else
        begin
            case (idx)
                0, 5: t = 1;
                1, 4: t = 5;
                default: t = 10;
            endcase
        end
        return t;
    endfunction

    function automatic int clamp_size(input logic [10:0] v);
        int s;
        s = int'(v);
        if (s < 2)
        begin
            s = 2;
        end
        if (s > STORE_WIDTH)
        begin
            s = STORE_WIDTH;
        end
        return s;
    endfunction

    // Weighted mean over the 6x6 window of output pixel (ox, oy).
    function automatic down_pixel_t window_mean(input int ox, input int oy, input int w,
                                                input int h, input int cur);
        down_pixel_t o;
        int unsigned rs, gs, bs, ks, wt;
        logic [24:0] p;
        int row, col;
        rs = 0; gs = 0; bs = 0; ks = 0;
        for (int dr = 0; dr < 6; dr++)
        begin
            row = 2 * ox - 2 + dr;
            if (row < 0 || row >= h)
            begin
                continue;
            end
            for (int dc = 0; dc < 6; dc++)
            begin
                col = 2 * oy - 2 + dc;
                if (col < 0 || col >= w)
                begin
                    continue;
                end
                p = (row == cur) ? row_tail[col & 7] : line_rows[(row % 5) * STORE_WIDTH + col];
                if (p[24])
                begin
                    continue;
                end
                wt = kern_tap(kern_sel, dr) * kern_tap(kern_sel, dc);
                rs += wt * p[7:0];
                gs += wt * p[15:8];
                bs += wt * p[23:16];
                ks += wt;
            end
        end
        if (ks > 0)
        begin
            o.red    = 8'(rs / ks);
            o.green  = 8'(gs / ks);
            o.blue   = 8'(bs / ks);
            o.masked = 1'b0;
        end
        else
        begin
            o.red = '0; o.green = '0; o.blue = '0;
            o.masked = 1'b1;
        end
        o.row  = 9'(ox);
        o.col  = 9'(oy);
        o.last = 1'b0;
        return o;
    endfunction

    // Accept one input pixel and queue the results it completes.
    function automatic void downsample_pixel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic m);
        int w, h, pr, pc, re, ce, n;
        w  = clamp_size(img_width);
        h  = clamp_size(img_height);
        pr = next_row;
        pc = next_col;
        n  = 0;
        if (pr >= h || pc >= w)
        begin
            pr = 0;
            pc = 0;
        end
        row_tail[pc & 7] = {m, b, g, r};
        for (int x = pr / 2 - 2; x <= pr / 2 + 1; x++)
        begin
            if (x < 0 || x >= h / 2)
            begin
                continue;
            end
            re = (2 * x + 3 > h - 1) ? h - 1 : 2 * x + 3;
            if (re != pr)
            begin
                continue;
            end
            for (int y = pc / 2 - 2; y <= pc / 2 + 1; y++)
            begin
                if (y < 0 || y >= w / 2)
                begin
                    continue;
                end
                ce = (2 * y + 3 > w - 1) ? w - 1 : 2 * y + 3;
                if (ce != pc || n >= 4)
                begin
                    continue;
                end
                expected_pixels.push_back(window_mean(x, y, w, h, pr));
                n++;
            end
        end
        if (n > 0)
        begin
            expected_pixels[expected_pixels.size() - 1].last = 1'b1;
        end
        // Retire tail pixels into the line rows.
        if (pc >= 5)
        begin
            line_rows[(pr % 5) * STORE_WIDTH + pc - 5] = row_tail[(pc - 5) & 7];
        end
        if (pc == w - 1)
        begin
            for (int q = (pc >= 4) ? pc - 4 : 0; q <= pc; q++)
            begin
                line_rows[(pr % 5) * STORE_WIDTH + q] = row_tail[q & 7];
            end
            pc = 0;
            pr++;
            if (pr >= h)
            begin
                pr = 0;
            end
        end
        else
        begin
            pc++;
        end
        next_row = pr;
        next_col = pc;
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        down_pixel_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result: tdata %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                e = expected_pixels.pop_front();
                if (m_axis_tdata[7:0] !== e.red)
                begin
                    $error("red_out: expected %0d, got %0d", e.red, m_axis_tdata[7:0]);
                    fail_count++;
                end
                if (m_axis_tdata[15:8] !== e.green)
                begin
                    $error("green_out: expected %0d, got %0d", e.green, m_axis_tdata[15:8]);
                    fail_count++;
                end
                if (m_axis_tdata[23:16] !== e.blue)
                begin
                    $error("blue_out: expected %0d, got %0d", e.blue, m_axis_tdata[23:16]);
                    fail_count++;
                end
                if (m_axis_tdata[32:24] !== e.row)
                begin
                    $error("out_row: expected %0d, got %0d", e.row, m_axis_tdata[32:24]);
                    fail_count++;
                end
                if (m_axis_tdata[41:33] !== e.col)
                begin
                    $error("out_col: expected %0d, got %0d", e.col, m_axis_tdata[41:33]);
                    fail_count++;
                end
                if (m_axis_tuser !== e.masked)
                begin
                    $error("masked_out: expected %0d, got %0d", e.masked, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $error("run_last: expected %0d, got %0d", e.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Offer one pixel; valid stays high afterwards until the next call decides.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic m);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        s_axis_tuser  <= m;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        downsample_pixel(r, g, b, m);
        pixels_sent++;
    endtask

    task automatic stop_stream;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Register write once the block has gone quiet.
    task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
        stop_stream();
        wait (expected_pixels.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            mids_pkg::REG_IMAGE_WIDTH:   img_width  = val;
            mids_pkg::REG_IMAGE_HEIGHT:  img_height = val;
            mids_pkg::REG_KERNEL_SELECT: kern_sel   = val[0];
            default: return;
        endcase
        next_row = 0;
        next_col = 0;
    endtask

    task automatic set_frame(input logic [10:0] w, input logic [10:0] h, input logic k);
        write_reg(mids_pkg::REG_IMAGE_WIDTH, w);
        write_reg(mids_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(mids_pkg::REG_KERNEL_SELECT, {10'd0, k});
    endtask

    // Extreme colors on a 4x4 frame, top-left corner masked, then an all-masked 2x2.
    task automatic test_directed_frames;
        set_frame(11'd4, 11'd4, 1'b0);
        for (int i = 0; i < 16; i++)
        begin
            if (i % 2 == 0)
            begin
                send_pixel(8'hFF, 8'hFF, 8'hFF, (i == 0 || i == 15));
            end
            else
            begin
                send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
            end
        end
        set_frame(11'd2, 11'd2, 1'b1);
        for (int i = 0; i < 4; i++)
        begin
            send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
        end
    endtask

    // Size registers out of range saturate; partial frames are restarted.
    task automatic test_size_saturation;
        set_frame(11'd0, 11'd1, 1'b0);
        for (int i = 0; i < 6; i++)
        begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        end
        set_frame(11'd2047, 11'd2, 1'b1);
        for (int i = 0; i < 12; i++)
        begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
        end
        set_frame(11'd2, 11'd2047, 1'b0);
        for (int i = 0; i < 14; i++)
        begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    // A write to the unused index must leave the frame position alone.
    task automatic test_unused_index;
        set_frame(11'd5, 11'd5, 1'b0);
        for (int i = 0; i < 7; i++)
        begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        end
        write_reg(REG_UNUSED, 11'h7FF);
        for (int i = 0; i < 18; i++)
        begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        end
    endtask

    // Random small frames, sometimes run past the end to wrap into a new one.
    task automatic test_random_frames(input int target);
        int w, h, density, count;
        while (pixels_sent < target)
        begin
            w = ($urandom_range(7) == 0) ? $urandom_range(10, 17) : $urandom_range(2, 9);
            h = $urandom_range(2, 9);
            case ($urandom_range(3))
                0: density = 0;
                1: density = 25;
                2: density = 90;
                default: density = 100;
            endcase
            set_frame(11'(w), 11'(h), 1'($urandom_range(1)));
            count = ($urandom_range(3) == 0) ? w * h + $urandom_range(1, w * h) : w * h;
            for (int i = 0; i < count; i++)
            begin
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                           ($urandom_range(99) < density));
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        fail_count    = 0;
        cycle_count   = 0;
        pixels_sent   = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        img_width     = 11'd640;
        img_height    = 11'd480;
        kern_sel      = 1'b0;
        next_row      = 0;
        next_col      = 0;
        for (int i = 0; i < 5 * STORE_WIDTH; i++)
        begin
            line_rows[i] = '0;
        end
        for (int i = 0; i < 8; i++)
        begin
            row_tail[i] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_size_saturation();
        test_unused_index();

        // Random part in four idling phases.
        test_random_frames(pixels_sent + 25);
        src_idle_pct = 52;
        test_random_frames(pixels_sent + 25);
        src_idle_pct  = 0;
        snk_stall_pct = 52;
        test_random_frames(pixels_sent + 25);
        src_idle_pct  = 14;
        snk_stall_pct = 14;
        test_random_frames(pixels_sent + 25);

        stop_stream();
        wait (expected_pixels.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mids_pkg.sv
hw/rtl/mids_ram.sv
hw/rtl/mids_lane.sv
hw/rtl/mids_merge.sv
hw/rtl/mids_div.sv
hw/rtl/masked_image_downsample.sv
hw/rtl/mids_checker.sv
sim/tb_masked_image_downsample.sv
